FILE: hw/rtl/mpool_pkg.sv
// Shared constants, types and the small pool divider for the max pool block.
`timescale 1ns / 1ps
package mpool_pkg;

  localparam int unsigned MAX_WIDTH    = 256;
  localparam int unsigned MAX_HEIGHT   = 256;
  localparam int unsigned MAX_CHANNELS = 64;
  localparam int unsigned MAX_POOL     = 8;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned INDEX_W  = 22;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned POOL_W = $clog2(MAX_POOL + 1);
  localparam int unsigned CRD_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned BIG_W  = (CRD_W > POOL_W) ? CRD_W : POOL_W;
  localparam int unsigned SUM_W  = BIG_W + 2;

  // Fixed-point scale of the pool reciprocals
  localparam int unsigned RECIP_SH = 11;
  localparam int unsigned PROD_W   = CRD_W + RECIP_SH + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 9;
  localparam int unsigned POOL_CFG_W   = 4;
  localparam int unsigned WIDTH_CFG_W  = 9;
  localparam int unsigned HEIGHT_CFG_W = 9;
  localparam int unsigned CHAN_CFG_W   = 7;

  localparam logic [POOL_CFG_W-1:0]   POOL_RST   = POOL_CFG_W'(2);
  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = WIDTH_CFG_W'(64);
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = HEIGHT_CFG_W'(64);
  localparam logic [CHAN_CFG_W-1:0]   CHAN_RST   = CHAN_CFG_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_CHANS  = 2'd3
  } cfg_reg_e;

  // Saturated configuration as the datapath sees it
  typedef struct packed {
    logic [POOL_W-1:0] pool;
    logic [COL_W:0]    width;
    logic [ROW_W:0]    height;
    logic [CH_W:0]     chans;
  } cfg_t;

  // One decoded sample on its way to the window update
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]         flat;
    logic [COL_W-1:0]           oc;
    logic                       in_win;
    logic                       start;
    logic                       fin;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic [CRD_W-1:0]  quot;
    logic [POOL_W-1:0] rem;
  } divres_t;

  // Divide a coordinate below 256 by the pool side: shift for powers of two,
  // scaled reciprocal otherwise; the rounding error stays below one step.
  function automatic divres_t pool_div(input logic [CRD_W-1:0] num,
                                       input logic [POOL_W-1:0] den);
    divres_t                 r;
    logic [PROD_W-1:0]       prod;
    logic [CRD_W+POOL_W-1:0] back;
    case (den)
      POOL_W'(2): prod = PROD_W'(num) << (RECIP_SH - 1);
      POOL_W'(3): prod = PROD_W'(num) * PROD_W'(683);
      POOL_W'(4): prod = PROD_W'(num) << (RECIP_SH - 2);
      POOL_W'(5): prod = PROD_W'(num) * PROD_W'(410);
      POOL_W'(6): prod = PROD_W'(num) * PROD_W'(342);
      POOL_W'(7): prod = PROD_W'(num) * PROD_W'(293);
      POOL_W'(8): prod = PROD_W'(num) << (RECIP_SH - 3);
      default:    prod = PROD_W'(num) << RECIP_SH;
    endcase
    r.quot = prod[RECIP_SH +: CRD_W];
    back   = (CRD_W + POOL_W)'(r.quot) * (CRD_W + POOL_W)'(den);
    r.rem  = POOL_W'(num - CRD_W'(back));
    return r;
  endfunction

endpackage

FILE: hw/rtl/max_pool_with_argmax.sv
// Streaming 2-D max pooling with argmax, top level.
// Path: after the edge that accepts the window's last sample, its result passes the input register,
// the store read and the result register; an output stall can hold it between them.
// Throughput: one sample per cycle, at most one store read and one store write per sample; a
// waiting result holds back input only once the next window result reaches the store.
// Reset: counters, flags and configuration reset at once; the column store is not cleared.
`timescale 1ns / 1ps
module max_pool_with_argmax (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // [15:0] sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,  // [15:0] max_value, [37:16] source_index
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [mpool_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mpool_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mpool_pkg::*;

  cfg_t                cfg;
  item_t               item;
  logic                adv, free;
  logic [SAMPLE_W-1:0] out_max;
  logic [INDEX_W-1:0]  out_index;

  mpool_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mpool_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_sample_i(s_axis_tdata[SAMPLE_W-1:0]),
    .next_free_i(free),
    .adv_o      (adv),
    .item_o     (item)
  );

  mpool_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .item_i     (item),
    .free_o     (free),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_max_o  (out_max),
    .out_index_o(out_index),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_index, out_max};

endmodule

FILE: hw/rtl/mpool_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mpool_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mpool_cfg.sv
// Configuration registers with saturation to the supported ranges.
`timescale 1ns / 1ps
module mpool_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mpool_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mpool_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output mpool_pkg::cfg_t                   cfg_o
);
  import mpool_pkg::*;

  logic [POOL_CFG_W-1:0]   pool_q,   pool_d;
  logic [WIDTH_CFG_W-1:0]  width_q,  width_d;
  logic [HEIGHT_CFG_W-1:0] height_q, height_d;
  logic [CHAN_CFG_W-1:0]   chans_q,  chans_d;

  always_comb begin
    pool_d   = pool_q;
    width_d  = width_q;
    height_d = height_q;
    chans_d  = chans_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_POOL:   pool_d   = cfg_data_i[POOL_CFG_W-1:0];
        REG_WIDTH:  width_d  = cfg_data_i[WIDTH_CFG_W-1:0];
        REG_HEIGHT: height_d = cfg_data_i[HEIGHT_CFG_W-1:0];
        REG_CHANS:  chans_d  = cfg_data_i[CHAN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q   <= POOL_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      chans_q  <= CHAN_RST;
    end else begin
      pool_q   <= pool_d;
      width_q  <= width_d;
      height_q <= height_d;
      chans_q  <= chans_d;
    end
  end

  // Saturate to 1..MAX
  always_comb begin
    if (pool_q == '0) begin
      cfg_o.pool = POOL_W'(1);
    end else if (32'(pool_q) > MAX_POOL) begin
      cfg_o.pool = POOL_W'(MAX_POOL);
    end else begin
      cfg_o.pool = POOL_W'(pool_q);
    end

    if (width_q == '0) begin
      cfg_o.width = (COL_W + 1)'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      cfg_o.width = (COL_W + 1)'(MAX_WIDTH);
    end else begin
      cfg_o.width = (COL_W + 1)'(width_q);
    end

    if (height_q == '0) begin
      cfg_o.height = (ROW_W + 1)'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      cfg_o.height = (ROW_W + 1)'(MAX_HEIGHT);
    end else begin
      cfg_o.height = (ROW_W + 1)'(height_q);
    end

    if (chans_q == '0) begin
      cfg_o.chans = (CH_W + 1)'(1);
    end else if (32'(chans_q) > MAX_CHANNELS) begin
      cfg_o.chans = (CH_W + 1)'(MAX_CHANNELS);
    end else begin
      cfg_o.chans = (CH_W + 1)'(chans_q);
    end
  end

endmodule

FILE: hw/rtl/mpool_front.sv
// Position counters, input register and window decode of each sample.
`timescale 1ns / 1ps
module mpool_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mpool_pkg::cfg_t                   cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mpool_pkg::SAMPLE_W-1:0]    in_sample_i,
  input  logic                              next_free_i,
  output logic                              adv_o,
  output mpool_pkg::item_t                  item_o
);
  import mpool_pkg::*;

  // Coordinates of the next sample to arrive
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [INDEX_W-1:0] flat_q, flat_d;

  // Input register
  logic                       v1_q, v1_d;
  logic signed [SAMPLE_W-1:0] smp1_q;
  logic [COL_W-1:0]           col1_q;
  logic [ROW_W-1:0]           row1_q;
  logic [CH_W-1:0]            ch1_q;
  logic [INDEX_W-1:0]         flat1_q;

  logic           accept;
  logic [COL_W:0] col_inc;
  logic [ROW_W:0] row_inc;
  logic [CH_W:0]  ch_inc;

  divres_t          dc, dr;
  logic [COL_W-1:0] col_base;
  logic [ROW_W-1:0] row_base;
  logic [SUM_W-1:0] col_end, row_end, p_ext;
  logic             in_col, in_row, last_col, last_row, last_ch;
  logic [POOL_W-1:0] p_top;

  assign adv_o      = v1_q && next_free_i;
  assign in_ready_o = !v1_q || next_free_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_inc = {1'b0, col_q} + (COL_W + 1)'(1);
    row_inc = {1'b0, row_q} + (ROW_W + 1)'(1);
    ch_inc  = {1'b0, ch_q} + (CH_W + 1)'(1);
    col_d   = col_q;
    row_d   = row_q;
    ch_d    = ch_q;
    flat_d  = flat_q;
    if (accept) begin
      flat_d = flat_q + INDEX_W'(1);
      col_d  = col_inc[COL_W-1:0];
      if (col_inc >= cfg_i.width) begin
        col_d = '0;
        row_d = row_inc[ROW_W-1:0];
        if (row_inc >= cfg_i.height) begin
          row_d = '0;
          ch_d  = ch_inc[CH_W-1:0];
          if (ch_inc >= cfg_i.chans) begin
            ch_d   = '0;
            flat_d = '0;
          end
        end
      end
    end
  end

  always_comb begin
    v1_d = v1_q;
    if (accept) begin
      v1_d = 1'b1;
    end else if (adv_o) begin
      v1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ch_q   <= '0;
      flat_q <= '0;
      v1_q   <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ch_q   <= ch_d;
      flat_q <= flat_d;
      v1_q   <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp1_q  <= in_sample_i;
      col1_q  <= col_q;
      row1_q  <= row_q;
      ch1_q   <= ch_q;
      flat1_q <= flat_q;
    end
  end

  // Window decode: a sample lies in a whole window when its window base
  // plus the side still fits in the plane.
  always_comb begin
    dc       = pool_div(CRD_W'(col1_q), cfg_i.pool);
    dr       = pool_div(CRD_W'(row1_q), cfg_i.pool);
    col_base = col1_q - COL_W'(dc.rem);
    row_base = row1_q - ROW_W'(dr.rem);
    p_ext    = SUM_W'(cfg_i.pool);
    col_end  = SUM_W'(col_base) + p_ext;
    row_end  = SUM_W'(row_base) + p_ext;
    in_col   = col_end <= SUM_W'(cfg_i.width);
    in_row   = row_end <= SUM_W'(cfg_i.height);
    last_col = (col_end + p_ext) > SUM_W'(cfg_i.width);
    last_row = (row_end + p_ext) > SUM_W'(cfg_i.height);
    last_ch  = ({1'b0, ch1_q} + (CH_W + 1)'(1)) == cfg_i.chans;
    p_top    = cfg_i.pool - POOL_W'(1);

    item_o.sample = smp1_q;
    item_o.flat   = flat1_q;
    item_o.oc     = COL_W'(dc.quot);
    item_o.in_win = in_col && in_row;
    item_o.start  = (dc.rem == '0) && (dr.rem == '0);
    item_o.fin    = (dc.rem == p_top) && (dr.rem == p_top);
    item_o.last   = last_ch && last_col && last_row;
  end

endmodule

FILE: hw/rtl/mpool_update.sv
// Per-column running max store, compare and update, and result register.
`timescale 1ns / 1ps
module mpool_update (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  mpool_pkg::item_t                item_i,
  output logic                            free_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mpool_pkg::SAMPLE_W-1:0]  out_max_o,
  output logic [mpool_pkg::INDEX_W-1:0]   out_index_o,
  output logic                            out_last_o
);
  import mpool_pkg::*;

  localparam int unsigned ENTRY_W = SAMPLE_W + INDEX_W;

  logic  v2_q, v2_d;
  item_t it2_q;

  // Last store write, forwarded over the registered read
  logic                lw_v_q;
  logic [COL_W-1:0]    lw_addr_q;
  logic [ENTRY_W-1:0]  lw_data_q;

  logic                ov_q, ov_d;
  logic [SAMPLE_W-1:0] omax_q;
  logic [INDEX_W-1:0]  oidx_q;
  logic                olast_q;

  logic [ENTRY_W-1:0]         rdata, cur, new_entry;
  logic signed [SAMPLE_W-1:0] cur_max;
  logic                       take, emit, out_free, go, we;

  mpool_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_WIDTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(it2_q.oc),
    .wdata_i(new_entry),
    .re_i   (adv_i && item_i.in_win),
    .raddr_i(item_i.oc),
    .rdata_o(rdata)
  );

  always_comb begin
    cur       = (lw_v_q && (lw_addr_q == it2_q.oc)) ? lw_data_q : rdata;
    cur_max   = $signed(cur[SAMPLE_W-1:0]);
    take      = it2_q.start || ($signed(it2_q.sample) > cur_max);
    new_entry = take ? {it2_q.flat, it2_q.sample} : cur;
    emit      = v2_q && it2_q.in_win && it2_q.fin;
    out_free  = !ov_q || out_ready_i;
    go        = v2_q && (!emit || out_free);
    we        = go && it2_q.in_win && take;
    free_o    = !v2_q || go;
  end

  always_comb begin
    v2_d = v2_q;
    if (free_o) begin
      v2_d = adv_i;
    end
    ov_d = ov_q;
    if (go && emit) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      ov_q   <= 1'b0;
      lw_v_q <= 1'b0;
    end else begin
      v2_q <= v2_d;
      ov_q <= ov_d;
      if (we) begin
        lw_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it2_q <= item_i;
    end
    if (we) begin
      lw_addr_q <= it2_q.oc;
      lw_data_q <= new_entry;
    end
    if (go && emit) begin
      omax_q  <= new_entry[SAMPLE_W-1:0];
      oidx_q  <= new_entry[ENTRY_W-1:SAMPLE_W];
      olast_q <= it2_q.last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_max_o   = omax_q;
  assign out_index_o = oidx_q;
  assign out_last_o  = olast_q;

endmodule
